@@ rtl/bba_pkg.sv @@
`default_nettype none

package bba_pkg;

   localparam int MIN_GRANULE_ORDER_C = 5;
   localparam int TOP_LEVEL_C         = 7;
   localparam int ROOT_BLOCKS_C       = 16;
   localparam int HEADER_BYTES_C      = 24;
   localparam int PAGE_BYTES_C        = 256;

   typedef struct packed {
      logic        req_type;
      logic [15:0] request_size;
      logic [15:0] payload_offset;
   } bba_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] result_offset;
   } bba_rsp_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_ZERO_SIZE = 3'd1,
      STAT_TOO_LARGE = 3'd2,
      STAT_NO_MEMORY = 3'd3,
      STAT_BAD_FREE  = 3'd4
   } bba_status_type;

   typedef enum logic [1:0] {
      TAG_NONE = 2'd0,
      TAG_FREE = 2'd1,
      TAG_USED = 2'd2
   } bba_tag_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_CHK,
      ST_A_SRCH,
      ST_A_TAKE0,
      ST_A_TAKE1,
      ST_A_SP2,
      ST_A_SP3,
      ST_A_SP4,
      ST_F_CHK,
      ST_F_TAG,
      ST_F_M0,
      ST_F_M1,
      ST_F_PUSH,
      ST_F_PUSH2,
      ST_DONE
   } bba_state_type;

   // Largest page reachable by doubling that still fits in half a root block.
   function automatic int page_limit(input int page, input int half);
      int p;
      p = page;
      for (int i = 0; i < 32; i++) begin
         if (p * 2 <= half) begin
            p = p * 2;
         end
      end
      return p;
   endfunction

endpackage

`default_nettype wire

@@ rtl/buddy_block_allocator_unit.sv @@
`default_nettype none
// Channel   Direction  Payload        Handshake
// req_      in         bba_req_type   req_valid / req_stall
// rsp_      out        bba_rsp_type   rsp_valid / rsp_stall
//
// One request at a time; an allocation costs more for each split level and for
// each empty level searched, a free more for each merge level.
// The cost is set by the single-port link and header memories, touched in turn.
// After reset the header tags are cleared, one granule a cycle, across all
// ROOT_BLOCKS << TOP_LEVEL granules (2048 by default) before req_stall drops.
// A result is held in its output register until rsp_stall is low.

module buddy_block_allocator_unit #(
   parameter int MIN_GRANULE_ORDER = bba_pkg::MIN_GRANULE_ORDER_C,
   parameter int TOP_LEVEL         = bba_pkg::TOP_LEVEL_C,
   parameter int ROOT_BLOCKS       = bba_pkg::ROOT_BLOCKS_C,
   parameter int HEADER_BYTES      = bba_pkg::HEADER_BYTES_C,
   parameter int PAGE_BYTES        = bba_pkg::PAGE_BYTES_C
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire bba_pkg::bba_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output bba_pkg::bba_rsp_type      rsp_data
);

   localparam int GRANULES   = ROOT_BLOCKS << TOP_LEVEL;
   localparam int GW         = $clog2(GRANULES);
   localparam int LW         = $clog2(GRANULES + 1);
   localparam int VW         = $clog2(TOP_LEVEL + 1);
   localparam int SW         = $clog2(TOP_LEVEL + 2);
   localparam int RTW        = $clog2(ROOT_BLOCKS + 1);
   localparam int HW         = 2 + VW;
   localparam int HALF_ROOT  = (1 << (TOP_LEVEL + MIN_GRANULE_ORDER)) / 2;
   localparam int PAGE_MAX   = bba_pkg::page_limit(PAGE_BYTES, HALF_ROOT);
   localparam bit ALWAYS_BIG = PAGE_BYTES > HALF_ROOT;
   localparam logic [LW-1:0] LINK_NONE = LW'(GRANULES);

   bba_pkg::bba_state_type state_ff, state_in;

   bba_pkg::bba_req_type req_ff;
   logic [VW-1:0]  lvl_ff, lvl_in;
   logic [SW-1:0]  s_ff, s_in;
   logic [GW-1:0]  g_ff, g_in;
   logic [GW-1:0]  r_ff, r_in;
   logic [LW-1:0]  h_ff, h_in;
   logic [RTW-1:0] roots_ff, roots_in;
   logic [GW-1:0]  clr_ff, clr_in;
   logic [2:0]     status_ff, status_in;
   logic [15:0]    offset_ff, offset_in;
   logic [LW-1:0]  heads_ff [TOP_LEVEL + 1];

   logic [VW-1:0]  head_idx;
   logic           head_we;
   logic [LW-1:0]  head_wdata;
   logic [LW-1:0]  head_rd;

   logic [GW-1:0]  hdr_addr, nxt_addr, prv_addr;
   logic           hdr_we, nxt_we, prv_we;
   logic [HW-1:0]  hdr_wdata, hdr_rdata;
   logic [LW-1:0]  nxt_wdata, nxt_rdata, prv_wdata, prv_rdata;

   logic           accept;
   logic [16:0]    need;
   logic [17:0]    want;
   logic [VW-1:0]  lvl_calc;
   logic [15:0]    base;
   logic [31:0]    g_wide;
   logic [GW-1:0]  buddy;
   logic [1:0]     hdr_tag;
   logic [VW-1:0]  hdr_lvl;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != bba_pkg::ST_IDLE;
   assign rsp_valid = state_ff == bba_pkg::ST_DONE;
   assign rsp_data  = '{status: status_ff, result_offset: offset_ff};

   assign head_rd = heads_ff[head_idx];
   assign hdr_tag = hdr_rdata[HW-1 -: 2];
   assign hdr_lvl = hdr_rdata[VW-1:0];
   assign need    = 17'(req_ff.request_size) + 17'(HEADER_BYTES);
   assign want    = 18'(need) + 18'(HEADER_BYTES);
   assign base    = req_ff.payload_offset - 16'(HEADER_BYTES);
   assign g_wide  = 32'(base) >> MIN_GRANULE_ORDER;
   assign buddy   = g_ff ^ (GW'(1) << lvl_ff);

   always_comb begin
      lvl_calc = VW'(TOP_LEVEL);
      for (int l = TOP_LEVEL - 1; l >= 0; l--) begin
         if (33'(need) <= (33'(1) << (l + MIN_GRANULE_ORDER))) begin
            lvl_calc = VW'(l);
         end
      end
   end

   bba_ram #(.WIDTH(HW), .DEPTH(GRANULES)) u_hdr_ram (
      .clock(clock), .addr(hdr_addr), .wr_en(hdr_we),
      .wr_data(hdr_wdata), .rd_data(hdr_rdata));

   bba_ram #(.WIDTH(LW), .DEPTH(GRANULES)) u_next_ram (
      .clock(clock), .addr(nxt_addr), .wr_en(nxt_we),
      .wr_data(nxt_wdata), .rd_data(nxt_rdata));

   bba_ram #(.WIDTH(LW), .DEPTH(GRANULES)) u_prev_ram (
      .clock(clock), .addr(prv_addr), .wr_en(prv_we),
      .wr_data(prv_wdata), .rd_data(prv_rdata));

   always_comb begin
      state_in   = state_ff;
      lvl_in     = lvl_ff;
      s_in       = s_ff;
      g_in       = g_ff;
      r_in       = r_ff;
      h_in       = h_ff;
      roots_in   = roots_ff;
      clr_in     = clr_ff;
      status_in  = status_ff;
      offset_in  = offset_ff;
      head_idx   = lvl_ff;
      head_we    = 1'b0;
      head_wdata = LINK_NONE;
      hdr_addr   = g_ff;
      hdr_we     = 1'b0;
      hdr_wdata  = {bba_pkg::TAG_NONE, VW'(0)};
      nxt_addr   = g_ff;
      nxt_we     = 1'b0;
      nxt_wdata  = LINK_NONE;
      prv_addr   = g_ff;
      prv_we     = 1'b0;
      prv_wdata  = LINK_NONE;

      case (state_ff)
         bba_pkg::ST_CLEAR: begin
            hdr_addr = clr_ff;
            hdr_we   = 1'b1;
            clr_in   = clr_ff + GW'(1);
            if (clr_ff == GW'(GRANULES - 1)) begin
               state_in = bba_pkg::ST_IDLE;
            end
         end
         bba_pkg::ST_IDLE: begin
            if (accept) begin
               status_in = bba_pkg::STAT_OK;
               offset_in = '0;
               state_in  = (req_data.req_type == bba_pkg::OP_FREE) ?
                           bba_pkg::ST_F_CHK : bba_pkg::ST_A_CHK;
            end
         end
         bba_pkg::ST_A_CHK: begin
            if (req_ff.request_size == 16'd0) begin
               status_in = bba_pkg::STAT_ZERO_SIZE;
               state_in  = bba_pkg::ST_DONE;
            end else if (ALWAYS_BIG || (32'(want) > 32'(PAGE_MAX))) begin
               status_in = bba_pkg::STAT_TOO_LARGE;
               state_in  = bba_pkg::ST_DONE;
            end else begin
               lvl_in   = lvl_calc;
               s_in     = SW'(lvl_calc);
               state_in = bba_pkg::ST_A_SRCH;
            end
         end
         bba_pkg::ST_A_SRCH: begin
            if (s_ff > SW'(TOP_LEVEL)) begin
               head_idx = VW'(TOP_LEVEL);
               if (32'(roots_ff) >= 32'(ROOT_BLOCKS)) begin
                  status_in = bba_pkg::STAT_NO_MEMORY;
                  state_in  = bba_pkg::ST_DONE;
               end else begin
                  // Fresh root: the top-level list is empty, so it becomes a lone head.
                  g_in       = GW'(32'(roots_ff) << TOP_LEVEL);
                  hdr_addr   = g_in;
                  hdr_we     = 1'b1;
                  hdr_wdata  = {bba_pkg::TAG_FREE, VW'(TOP_LEVEL)};
                  nxt_addr   = g_in;
                  nxt_we     = 1'b1;
                  prv_addr   = g_in;
                  prv_we     = 1'b1;
                  head_we    = 1'b1;
                  head_wdata = LW'(g_in);
                  roots_in   = roots_ff + RTW'(1);
                  s_in       = SW'(TOP_LEVEL);
                  state_in   = bba_pkg::ST_A_TAKE0;
               end
            end else begin
               head_idx = s_ff[VW-1:0];
               if (head_rd == LINK_NONE) begin
                  s_in = s_ff + SW'(1);
               end else begin
                  state_in = bba_pkg::ST_A_TAKE0;
               end
            end
         end
         bba_pkg::ST_A_TAKE0: begin
            head_idx = s_ff[VW-1:0];
            g_in     = head_rd[GW-1:0];
            nxt_addr = g_in;
            state_in = bba_pkg::ST_A_TAKE1;
         end
         bba_pkg::ST_A_TAKE1: begin
            // Pop the head of level s; its successor becomes the new head.
            head_idx   = s_ff[VW-1:0];
            head_we    = 1'b1;
            head_wdata = nxt_rdata;
            prv_addr   = nxt_rdata[GW-1:0];
            prv_we     = nxt_rdata != LINK_NONE;
            if (s_ff == SW'(lvl_ff)) begin
               hdr_we    = 1'b1;
               hdr_wdata = {bba_pkg::TAG_USED, lvl_ff};
               offset_in = 16'((32'(g_ff) << MIN_GRANULE_ORDER) + 32'(HEADER_BYTES));
               state_in  = bba_pkg::ST_DONE;
            end else begin
               r_in      = g_ff + (GW'(1) << (s_ff - SW'(1)));
               hdr_addr  = r_in;
               hdr_we    = 1'b1;
               hdr_wdata = {bba_pkg::TAG_FREE, VW'(s_ff - SW'(1))};
               state_in  = bba_pkg::ST_A_SP2;
            end
         end
         bba_pkg::ST_A_SP2: begin
            head_idx  = VW'(s_ff - SW'(1));
            h_in      = head_rd;
            nxt_addr  = r_ff;
            nxt_we    = 1'b1;
            nxt_wdata = head_rd;
            prv_addr  = r_ff;
            prv_we    = 1'b1;
            prv_wdata = LW'(g_ff);
            hdr_we    = 1'b1;
            hdr_wdata = {bba_pkg::TAG_FREE, VW'(s_ff - SW'(1))};
            state_in  = bba_pkg::ST_A_SP3;
         end
         bba_pkg::ST_A_SP3: begin
            head_idx   = VW'(s_ff - SW'(1));
            head_we    = 1'b1;
            head_wdata = LW'(g_ff);
            nxt_we     = 1'b1;
            nxt_wdata  = LW'(r_ff);
            prv_we     = 1'b1;
            state_in   = bba_pkg::ST_A_SP4;
         end
         bba_pkg::ST_A_SP4: begin
            prv_addr  = h_ff[GW-1:0];
            prv_we    = h_ff != LINK_NONE;
            prv_wdata = LW'(r_ff);
            s_in      = s_ff - SW'(1);
            state_in  = bba_pkg::ST_A_TAKE0;
         end
         bba_pkg::ST_F_CHK: begin
            g_in     = g_wide[GW-1:0];
            hdr_addr = g_in;
            if ((req_ff.payload_offset < 16'(HEADER_BYTES)) ||
                (base[MIN_GRANULE_ORDER-1:0] != '0) ||
                (g_wide >= (32'(roots_ff) << TOP_LEVEL))) begin
               status_in = bba_pkg::STAT_BAD_FREE;
               state_in  = bba_pkg::ST_DONE;
            end else begin
               state_in = bba_pkg::ST_F_TAG;
            end
         end
         bba_pkg::ST_F_TAG: begin
            if (hdr_tag != bba_pkg::TAG_USED) begin
               status_in = bba_pkg::STAT_BAD_FREE;
               state_in  = bba_pkg::ST_DONE;
            end else begin
               lvl_in   = hdr_lvl;
               state_in = bba_pkg::ST_F_M0;
            end
         end
         bba_pkg::ST_F_M0: begin
            hdr_addr = buddy;
            nxt_addr = buddy;
            prv_addr = buddy;
            state_in = (lvl_ff == VW'(TOP_LEVEL)) ? bba_pkg::ST_F_PUSH : bba_pkg::ST_F_M1;
         end
         bba_pkg::ST_F_M1: begin
            if ((hdr_tag != bba_pkg::TAG_FREE) || (hdr_lvl != lvl_ff)) begin
               state_in = bba_pkg::ST_F_PUSH;
            end else begin
               // Unlink the free buddy; a buddy at the head moves the head.
               nxt_addr  = prv_rdata[GW-1:0];
               nxt_we    = prv_rdata != LINK_NONE;
               nxt_wdata = nxt_rdata;
               if (prv_rdata == LINK_NONE) begin
                  head_we    = 1'b1;
                  head_wdata = nxt_rdata;
               end
               prv_addr  = nxt_rdata[GW-1:0];
               prv_we    = nxt_rdata != LINK_NONE;
               prv_wdata = prv_rdata;
               hdr_addr  = (buddy < g_ff) ? g_ff : buddy;
               hdr_we    = 1'b1;
               g_in      = (buddy < g_ff) ? buddy : g_ff;
               lvl_in    = lvl_ff + VW'(1);
               state_in  = bba_pkg::ST_F_M0;
            end
         end
         bba_pkg::ST_F_PUSH: begin
            h_in       = head_rd;
            hdr_we     = 1'b1;
            hdr_wdata  = {bba_pkg::TAG_FREE, lvl_ff};
            nxt_we     = 1'b1;
            nxt_wdata  = head_rd;
            prv_we     = 1'b1;
            head_we    = 1'b1;
            head_wdata = LW'(g_ff);
            state_in   = bba_pkg::ST_F_PUSH2;
         end
         bba_pkg::ST_F_PUSH2: begin
            prv_addr  = h_ff[GW-1:0];
            prv_we    = h_ff != LINK_NONE;
            prv_wdata = LW'(g_ff);
            state_in  = bba_pkg::ST_DONE;
         end
         bba_pkg::ST_DONE: begin
            if (!rsp_stall) begin
               state_in = bba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::ST_CLEAR;
         roots_ff <= '0;
         clr_ff   <= '0;
         for (int i = 0; i <= TOP_LEVEL; i++) begin
            heads_ff[i] <= LINK_NONE;
         end
      end else begin
         state_ff <= state_in;
         roots_ff <= roots_in;
         clr_ff   <= clr_in;
         if (head_we) begin
            heads_ff[head_idx] <= head_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      lvl_ff    <= lvl_in;
      s_ff      <= s_in;
      g_ff      <= g_in;
      r_ff      <= r_in;
      h_ff      <= h_in;
      status_ff <= status_in;
      offset_ff <= offset_in;
   end

   roots_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(roots_ff) <= 32'(ROOT_BLOCKS))
      else $error("more root blocks taken than the pool holds");

   take_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == bba_pkg::ST_A_TAKE0 |-> head_rd != LINK_NONE)
      else $error("popping from an empty level list");

   no_early_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> !rsp_valid)
      else $error("result presented in the cycle after the request transfer");

   merge_climbs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bba_pkg::ST_F_M1 && state_in == bba_pkg::ST_F_M0)
      |=> lvl_ff == $past(lvl_ff) + VW'(1))
      else $error("merge did not move up one level");

endmodule

`default_nettype wire

@@ rtl/bba_ram.sv @@
`default_nettype none

module bba_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic                     wr_en,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

`default_nettype wire

@@ sim/buddy_block_allocator_unit_test.sv @@
`timescale 1ns / 1ps

module buddy_block_allocator_unit_test;

   localparam int GRANULES   = bba_pkg::ROOT_BLOCKS_C << bba_pkg::TOP_LEVEL_C;
   localparam int LINK_NONE  = GRANULES;
   localparam int ROOT_GRAN  = 1 << bba_pkg::TOP_LEVEL_C;
   localparam int HALF_ROOT  =
      (1 << (bba_pkg::TOP_LEVEL_C + bba_pkg::MIN_GRANULE_ORDER_C)) / 2;
   localparam int RAND_ITEMS = 1030;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   bba_pkg::bba_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   bba_pkg::bba_rsp_type rsp_data;

   buddy_block_allocator_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Shadow copy of the allocator state.
   int                   free_head [0:bba_pkg::TOP_LEVEL_C];
   int                   next_gran [0:GRANULES-1];
   int                   prev_gran [0:GRANULES-1];
   bba_pkg::bba_tag_type gran_tag  [0:GRANULES-1];
   int                   gran_lvl  [0:GRANULES-1];
   int                   roots_used;

   bba_pkg::bba_rsp_type expected_rsp_q[$];
   int                   live_offsets[$];
   int                   failures;
   int                   accepted;
   bit                   stim_done;

   function automatic void push_free(int lvl, int g);
      int h;
      h = free_head[lvl];
      next_gran[g] = h;
      prev_gran[g] = LINK_NONE;
      if (h < GRANULES) prev_gran[h] = g;
      free_head[lvl] = g;
   endfunction

   function automatic void unlink_free(int lvl, int g);
      int p;
      int n;
      p = prev_gran[g];
      n = next_gran[g];
      if (p < GRANULES) next_gran[p] = n;
      else free_head[lvl] = n;
      if (n < GRANULES) prev_gran[n] = p;
      next_gran[g] = LINK_NONE;
      prev_gran[g] = LINK_NONE;
   endfunction

   function automatic bba_pkg::bba_rsp_type allocate_block(int size);
      bba_pkg::bba_rsp_type r;
      int page;
      int lvl;
      int mem;
      int s;
      int g;
      r = '0;
      if (size == 0) begin
         r.status = bba_pkg::STAT_ZERO_SIZE;
         return r;
      end
      page = bba_pkg::PAGE_BYTES_C;
      while (page < size + 2 * bba_pkg::HEADER_BYTES_C && page <= HALF_ROOT) page *= 2;
      if (page > HALF_ROOT) begin
         r.status = bba_pkg::STAT_TOO_LARGE;
         return r;
      end
      lvl = 0;
      mem = 1 << bba_pkg::MIN_GRANULE_ORDER_C;
      while (size + bba_pkg::HEADER_BYTES_C > mem && lvl < bba_pkg::TOP_LEVEL_C) begin
         mem *= 2;
         lvl++;
      end
      s = lvl;
      while (s <= bba_pkg::TOP_LEVEL_C && free_head[s] >= GRANULES) s++;
      if (s > bba_pkg::TOP_LEVEL_C) begin
         if (roots_used >= bba_pkg::ROOT_BLOCKS_C) begin
            r.status = bba_pkg::STAT_NO_MEMORY;
            return r;
         end
         g = roots_used * ROOT_GRAN;
         roots_used++;
         gran_tag[g] = bba_pkg::TAG_FREE;
         gran_lvl[g] = bba_pkg::TOP_LEVEL_C;
         push_free(bba_pkg::TOP_LEVEL_C, g);
         s = bba_pkg::TOP_LEVEL_C;
      end
      while (s > lvl) begin
         g = free_head[s];
         unlink_free(s, g);
         gran_tag[g + (1 << (s - 1))] = bba_pkg::TAG_FREE;
         gran_lvl[g + (1 << (s - 1))] = s - 1;
         gran_lvl[g] = s - 1;
         push_free(s - 1, g + (1 << (s - 1)));
         push_free(s - 1, g);
         s--;
      end
      g = free_head[lvl];
      unlink_free(lvl, g);
      gran_tag[g] = bba_pkg::TAG_USED;
      gran_lvl[g] = lvl;
      r.status = bba_pkg::STAT_OK;
      r.result_offset =
         16'((g << bba_pkg::MIN_GRANULE_ORDER_C) + bba_pkg::HEADER_BYTES_C);
      return r;
   endfunction

   function automatic bba_pkg::bba_rsp_type release_block(int off);
      bba_pkg::bba_rsp_type r;
      int base;
      int g;
      int lvl;
      int root;
      int b;
      r = '0;
      r.status = bba_pkg::STAT_BAD_FREE;
      if (off < bba_pkg::HEADER_BYTES_C) return r;
      base = off - bba_pkg::HEADER_BYTES_C;
      if ((base & ((1 << bba_pkg::MIN_GRANULE_ORDER_C) - 1)) != 0) return r;
      g = base >> bba_pkg::MIN_GRANULE_ORDER_C;
      if (g >= roots_used * ROOT_GRAN || g >= GRANULES ||
          gran_tag[g] != bba_pkg::TAG_USED) return r;
      lvl = gran_lvl[g];
      root = g & ~(ROOT_GRAN - 1);
      while (lvl < bba_pkg::TOP_LEVEL_C) begin
         b = root + ((g - root) ^ (1 << lvl));
         if (gran_tag[b] != bba_pkg::TAG_FREE || gran_lvl[b] != lvl) break;
         unlink_free(lvl, b);
         if (b < g) begin
            gran_tag[g] = bba_pkg::TAG_NONE;
            g = b;
         end else begin
            gran_tag[b] = bba_pkg::TAG_NONE;
         end
         lvl++;
      end
      gran_tag[g] = bba_pkg::TAG_FREE;
      gran_lvl[g] = lvl;
      push_free(lvl, g);
      r.status = bba_pkg::STAT_OK;
      return r;
   endfunction

   // Updates the shadow state and the list of live payload offsets.
   function automatic bba_pkg::bba_rsp_type predict_rsp(bba_pkg::bba_req_type q);
      bba_pkg::bba_rsp_type r;
      if (q.req_type == bba_pkg::OP_ALLOC) begin
         r = allocate_block(int'(q.request_size));
         if (r.status == bba_pkg::STAT_OK) live_offsets.push_back(int'(r.result_offset));
      end else begin
         r = release_block(int'(q.payload_offset));
         if (r.status == bba_pkg::STAT_OK) begin
            foreach (live_offsets[i]) begin
               if (live_offsets[i] == int'(q.payload_offset)) begin
                  live_offsets.delete(i);
                  break;
               end
            end
         end
      end
      return r;
   endfunction

   typedef struct {
      logic                    op;
      int                      size;
      int                      off;
      bit                      typed;
      bba_pkg::bba_status_type stat;
      int                      res_off;
   } stim_row_type;

   stim_row_type directed[] = '{
      '{bba_pkg::OP_ALLOC, 1,     0,     1, bba_pkg::STAT_OK,        24},
      '{bba_pkg::OP_ALLOC, 0,     0,     1, bba_pkg::STAT_ZERO_SIZE, 0},
      '{bba_pkg::OP_ALLOC, 2001,  0,     1, bba_pkg::STAT_TOO_LARGE, 0},
      '{bba_pkg::OP_ALLOC, 65535, 0,     1, bba_pkg::STAT_TOO_LARGE, 0},
      '{bba_pkg::OP_FREE,  0,     0,     1, bba_pkg::STAT_BAD_FREE,  0},
      '{bba_pkg::OP_FREE,  0,     23,    1, bba_pkg::STAT_BAD_FREE,  0},
      '{bba_pkg::OP_FREE,  0,     25,    1, bba_pkg::STAT_BAD_FREE,  0},
      '{bba_pkg::OP_FREE,  0,     65535, 1, bba_pkg::STAT_BAD_FREE,  0},
      '{bba_pkg::OP_FREE,  0,     65528, 1, bba_pkg::STAT_BAD_FREE,  0},
      '{bba_pkg::OP_FREE,  0,     24,    1, bba_pkg::STAT_OK,        0},
      '{bba_pkg::OP_FREE,  0,     24,    1, bba_pkg::STAT_BAD_FREE,  0},
      '{bba_pkg::OP_ALLOC, 2000,  0,     0, bba_pkg::STAT_OK,        0},
      '{bba_pkg::OP_ALLOC, 8,     0,     0, bba_pkg::STAT_OK,        0},
      '{bba_pkg::OP_ALLOC, 9,     0,     0, bba_pkg::STAT_OK,        0},
      '{bba_pkg::OP_ALLOC, 40,    0,     0, bba_pkg::STAT_OK,        0},
      '{bba_pkg::OP_ALLOC, 1000,  0,     0, bba_pkg::STAT_OK,        0},
      '{bba_pkg::OP_FREE,  0,     88,    0, bba_pkg::STAT_OK,        0},
      '{bba_pkg::OP_FREE,  0,     56,    0, bba_pkg::STAT_OK,        0},
      '{bba_pkg::OP_FREE,  0,     4120,  0, bba_pkg::STAT_OK,        0},
      '{bba_pkg::OP_FREE,  0,     2072,  0, bba_pkg::STAT_OK,        0}
   };

   function automatic bba_pkg::bba_req_type random_req(int alloc_pct);
      bba_pkg::bba_req_type q;
      int pick;
      q.request_size   = 16'($urandom);
      q.payload_offset = 16'($urandom);
      pick = int'($urandom_range(99));
      if (pick < alloc_pct || live_offsets.size() == 0) begin
         q.req_type = bba_pkg::OP_ALLOC;
         pick = int'($urandom_range(99));
         if (pick < 70) q.request_size = 16'($urandom_range(1, 200));
         else if (pick < 92) q.request_size = 16'($urandom_range(1, 2000));
         else if (pick < 95) q.request_size = '0;
      end else begin
         q.req_type = bba_pkg::OP_FREE;
         if ($urandom_range(99) < 85)
            q.payload_offset =
               16'(live_offsets[$urandom_range(live_offsets.size() - 1)]);
      end
      return q;
   endfunction

   function automatic bit quiet_stretch();
      return accepted >= 500 && accepted < 700;
   endfunction

   // Request side: prediction is made at the edge where the transfer happens.
   initial begin
      bba_pkg::bba_req_type q;
      bba_pkg::bba_rsp_type want;
      int alloc_pct;
      int gap;
      failures  = 0;
      accepted  = 0;
      stim_done = 0;
      alloc_pct = 50;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      foreach (free_head[i]) free_head[i] = LINK_NONE;
      foreach (gran_tag[i]) gran_tag[i] = bba_pkg::TAG_NONE;
      roots_used = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < directed.size() + RAND_ITEMS; n++) begin
         if (n < directed.size()) begin
            q.req_type       = directed[n].op;
            q.request_size   = 16'(directed[n].size);
            q.payload_offset = 16'(directed[n].off);
         end else begin
            if ((n - directed.size()) % 150 == 0) begin
               case ($urandom_range(2))
                  0: alloc_pct = 30;
                  1: alloc_pct = 55;
                  default: alloc_pct = 85;
               endcase
            end
            q = random_req(alloc_pct);
         end
         req_valid <= 1'b1;
         req_data  <= q;
         do @(posedge clock); while (req_stall);
         want = predict_rsp(q);
         if (n < directed.size() && directed[n].typed) begin
            want.status        = directed[n].stat;
            want.result_offset = 16'(directed[n].res_off);
         end
         expected_rsp_q.push_back(want);
         accepted++;
         if (!quiet_stretch() && $urandom_range(99) < 22) begin
            gap = int'($urandom_range(1, 6));
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      stim_done = 1;
   end

   // Result side: checks each transfer and drives the stall.
   initial begin
      bba_pkg::bba_rsp_type want;
      bit held_off;
      rsp_stall = 1'b0;
      held_off  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected result status %0d offset %0d", $time,
                        rsp_data.status, rsp_data.result_offset);
               failures++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_data.status);
                  failures++;
               end
               if (rsp_data.result_offset !== want.result_offset) begin
                  $display("%0t: result_offset expected %0d actual %0d", $time,
                           want.result_offset, rsp_data.result_offset);
                  failures++;
               end
            end
         end
         if (!held_off && accepted >= 300) begin
            // Hold results back long enough for the input to back up.
            held_off = 1;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= !quiet_stretch() && $urandom_range(99) < 22;
         end
      end
   end

   initial begin
      wait (stim_done);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/buddy_block_allocator_unit.sv
sim/buddy_block_allocator_unit_test.sv
